// ===== design/nearest_pair_momentum_subtraction_core_macros.svh =====
// Assertion macros for the nearest-pair momentum subtraction core.
`ifndef NEAREST_PAIR_MOMENTUM_SUBTRACTION_CORE_MACROS_SVH
`define NEAREST_PAIR_MOMENTUM_SUBTRACTION_CORE_MACROS_SVH

// same-cycle implication
`define NPMS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define NPMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/npms_pkg.sv =====
// Shared types, constants and codes for the nearest-pair momentum subtraction core.
package npms_pkg;

   localparam int DefMaxParticles = 32;
   localparam int DefMaxThermals  = 32;
   localparam int MaxResults      = 64;
   localparam int ResCntW         = $clog2(MaxResults + 1);
   localparam int PiQ             = 12868;
   localparam int TwoPiQ          = 25736;
   localparam int DistW           = 33;
   localparam logic [DistW-1:0] MaxDistReset = 33'd1048576;

   localparam logic [1:0] OpLoadParticle = 2'd0;
   localparam logic [1:0] OpLoadThermal  = 2'd1;
   localparam logic [1:0] OpRun          = 2'd2;
   localparam logic [1:0] OpUnused       = 2'd3;

   localparam logic [1:0] KindParticle = 2'd0;
   localparam logic [1:0] KindThermal  = 2'd1;
   localparam logic [1:0] KindNone     = 2'd2;

   localparam logic [1:0] SelScan = 2'd0;
   localparam logic [1:0] SelBest = 2'd1;
   localparam logic [1:0] SelEmit = 2'd2;

   typedef struct packed {
      logic [31:0]        pt;
      logic [31:0]        mx;
      logic signed [14:0] az;
      logic signed [15:0] rap;
      logic [31:0]        species;
   } item_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [31:0]        species;
      logic [31:0]        pt;
      logic [31:0]        mx;
      logic signed [14:0] az;
      logic signed [15:0] rap;
      logic               overflow;
      logic               last;
   } result_type;

   typedef struct packed {
      logic       load_p;
      logic       load_t;
      logic       run_start;
      logic       round_start;
      logic       scan_issue;
      logic [1:0] addr_sel;
      logic       apply_wr;
      logic       emit_start;
      logic       emit_take;
      logic       emit_final;
   } cmd_type;

   typedef struct packed {
      logic no_pairs;
      logic scan_last;
      logic pipe_empty;
      logic best_ok;
      logic emit_done;
      logic survivor;
      logic held_valid;
      logic out_free;
   } status_type;

endpackage

// ===== design/npms_datapath.sv =====
// Datapath: item stores, distance pipeline, minimum search, subtraction and result register.
module npms_datapath #(
   parameter int MAX_PARTICLES = npms_pkg::DefMaxParticles,
   parameter int MAX_THERMALS  = npms_pkg::DefMaxThermals
) (
   input  logic                   clock,
   input  logic                   reset,
   input  npms_pkg::cmd_type      cmd,
   output npms_pkg::status_type   status,
   input  npms_pkg::item_type     req_item,
   input  logic                   csr_we,
   input  logic [npms_pkg::DistW-1:0] csr_wdata,
   input  logic                   rsp_tready,
   output logic                   rsp_valid,
   output npms_pkg::result_type   rsp_result
);

   localparam int IWP = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int IWT = (MAX_THERMALS > 1) ? $clog2(MAX_THERMALS) : 1;
   localparam int CWP = $clog2(MAX_PARTICLES + 1);
   localparam int CWT = $clog2(MAX_THERMALS + 1);
   localparam int EW  = $clog2(MAX_PARTICLES + MAX_THERMALS + 1);
   localparam int DW  = npms_pkg::DistW;
   localparam int KW  = DW + IWP + IWT;

   npms_pkg::item_type part_mem  [MAX_PARTICLES];
   npms_pkg::item_type therm_mem [MAX_THERMALS];

   npms_pkg::item_type p_rd_ff, t_rd_ff, p_wdata, t_wdata;
   logic [IWP-1:0] p_addr, p_waddr;
   logic [IWT-1:0] t_addr, t_waddr;
   logic           p_we, t_we;

   logic [CWP-1:0] pc_ff, pc_in;
   logic [CWT-1:0] tc_ff, tc_in;
   logic           ovf_ff, ovf_in;
   logic [DW-1:0]  max_ff;

   logic [IWP-1:0] si_ff;
   logic [IWT-1:0] sj_ff;

   logic           v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IWP-1:0] i1_ff, i2_ff, i3_ff;
   logic [IWT-1:0] j1_ff, j2_ff, j3_ff;
   logic signed [16:0] dph_ff, dy_ff;
   logic signed [33:0] sqp_ff, sqy_ff;
   logic [KW-1:0]  key4_ff, best_ff, last_ff;
   logic           found_ff, have_last_ff;

   logic signed [16:0] azd, azabs, dph, dy;
   logic [DW-1:0]  sum_d;

   logic [EW-1:0]  ek_ff;
   logic [npms_pkg::ResCntW-1:0] rcnt_ff;
   npms_pkg::result_type held_ff, new_res, out_ff, out_in;
   logic           held_v_ff, out_v_ff, push, is_part;
   logic [IWP-1:0] best_i;
   logic [IWT-1:0] best_j;

   assign best_i  = best_ff[IWT +: IWP];
   assign best_j  = best_ff[IWT-1:0];
   assign is_part = ek_ff < EW'(pc_ff);

   // read addresses
   always_comb begin
      unique case (cmd.addr_sel)
         npms_pkg::SelScan: begin
            p_addr = si_ff;
            t_addr = sj_ff;
         end
         npms_pkg::SelBest: begin
            p_addr = best_i;
            t_addr = best_j;
         end
         default: begin
            p_addr = IWP'(ek_ff);
            t_addr = IWT'(ek_ff - EW'(pc_ff));
         end
      endcase
   end

   // write ports: load or subtraction update
   always_comb begin
      p_wdata = p_rd_ff;
      t_wdata = t_rd_ff;
      if (p_rd_ff.pt > t_rd_ff.pt) begin
         p_wdata.pt = p_rd_ff.pt - t_rd_ff.pt;
         t_wdata.pt = '0;
      end else begin
         t_wdata.pt = t_rd_ff.pt - p_rd_ff.pt;
         p_wdata.pt = '0;
      end
      if (p_rd_ff.mx > t_rd_ff.mx) begin
         p_wdata.mx = p_rd_ff.mx - t_rd_ff.mx;
         t_wdata.mx = '0;
      end else begin
         t_wdata.mx = t_rd_ff.mx - p_rd_ff.mx;
         p_wdata.mx = '0;
      end
      p_waddr = best_i;
      t_waddr = best_j;
      p_we    = cmd.apply_wr;
      t_we    = cmd.apply_wr;
      if (cmd.load_p) begin
         p_wdata = req_item;
         p_waddr = IWP'(pc_ff);
         p_we    = pc_ff < CWP'(MAX_PARTICLES);
      end
      if (cmd.load_t) begin
         t_wdata         = req_item;
         t_wdata.species = '0;
         t_waddr         = IWT'(tc_ff);
         t_we            = tc_ff < CWT'(MAX_THERMALS);
      end
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         part_mem[p_waddr] <= p_wdata;
      end
      if (t_we) begin
         therm_mem[t_waddr] <= t_wdata;
      end
      p_rd_ff <= part_mem[p_addr];
      t_rd_ff <= therm_mem[t_addr];
   end

   // counts and overflow
   always_comb begin
      pc_in  = pc_ff;
      tc_in  = tc_ff;
      ovf_in = ovf_ff;
      if (cmd.load_p) begin
         if (pc_ff < CWP'(MAX_PARTICLES)) begin
            pc_in = pc_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.load_t) begin
         if (tc_ff < CWT'(MAX_THERMALS)) begin
            tc_in = tc_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.emit_final) begin
         pc_in  = '0;
         tc_in  = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         tc_ff  <= '0;
         ovf_ff <= 1'b0;
         max_ff <= npms_pkg::MaxDistReset;
      end else begin
         pc_ff  <= pc_in;
         tc_ff  <= tc_in;
         ovf_ff <= ovf_in;
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
      end
   end

   // distance arithmetic
   always_comb begin
      azd   = 17'(p_rd_ff.az) - 17'(t_rd_ff.az);
      azabs = (azd < 0) ? -azd : azd;
      dph   = (azabs > 17'(npms_pkg::PiQ)) ? 17'(npms_pkg::TwoPiQ) - azabs : azabs;
      dy    = 17'(p_rd_ff.rap) - 17'(t_rd_ff.rap);
      sum_d = DW'(sqp_ff) + DW'(sqy_ff);
   end

   // pair scan counters and pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         found_ff     <= 1'b0;
         have_last_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.scan_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (cmd.round_start) begin
            found_ff <= 1'b0;
         end else if (v4_ff && (!have_last_ff || key4_ff > last_ff)
                      && (!found_ff || key4_ff < best_ff)) begin
            found_ff <= 1'b1;
         end
         if (cmd.run_start) begin
            have_last_ff <= 1'b0;
         end else if (cmd.apply_wr) begin
            have_last_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.round_start) begin
         si_ff <= '0;
         sj_ff <= '0;
      end else if (cmd.scan_issue) begin
         if (CWT'(sj_ff) == tc_ff - 1'b1) begin
            sj_ff <= '0;
            si_ff <= si_ff + 1'b1;
         end else begin
            sj_ff <= sj_ff + 1'b1;
         end
      end
      i1_ff   <= si_ff;
      j1_ff   <= sj_ff;
      i2_ff   <= i1_ff;
      j2_ff   <= j1_ff;
      dph_ff  <= dph;
      dy_ff   <= dy;
      i3_ff   <= i2_ff;
      j3_ff   <= j2_ff;
      sqp_ff  <= dph_ff * dph_ff;
      sqy_ff  <= dy_ff * dy_ff;
      key4_ff <= {sum_d, i3_ff, j3_ff};
      if (v4_ff && (!have_last_ff || key4_ff > last_ff) && (!found_ff || key4_ff < best_ff)) begin
         best_ff <= key4_ff;
      end
      if (cmd.apply_wr) begin
         last_ff <= best_ff;
      end
   end

   // result assembly
   always_comb begin
      new_res          = '0;
      new_res.overflow = ovf_ff;
      if (is_part) begin
         new_res.kind    = npms_pkg::KindParticle;
         new_res.species = p_rd_ff.species;
         new_res.pt      = p_rd_ff.pt;
         new_res.mx      = p_rd_ff.mx;
         new_res.az      = p_rd_ff.az;
         new_res.rap     = p_rd_ff.rap;
      end else begin
         new_res.kind    = npms_pkg::KindThermal;
         new_res.pt      = t_rd_ff.pt;
         new_res.mx      = t_rd_ff.mx;
         new_res.az      = t_rd_ff.az;
         new_res.rap     = t_rd_ff.rap;
      end
      push = (cmd.emit_take && new_res.pt != '0 && held_v_ff) || cmd.emit_final;
      out_in = out_ff;
      if (cmd.emit_final) begin
         if (held_v_ff) begin
            out_in      = held_ff;
            out_in.last = 1'b1;
         end else begin
            out_in          = '0;
            out_in.kind     = npms_pkg::KindNone;
            out_in.overflow = ovf_ff;
            out_in.last     = 1'b1;
         end
      end else if (push) begin
         out_in = held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (cmd.emit_start) begin
            held_v_ff <= 1'b0;
         end else if (cmd.emit_take && new_res.pt != '0) begin
            held_v_ff <= 1'b1;
         end
         if (push) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_start) begin
         ek_ff   <= '0;
         rcnt_ff <= '0;
      end else if (cmd.emit_take) begin
         ek_ff <= ek_ff + 1'b1;
         if (new_res.pt != '0) begin
            rcnt_ff <= rcnt_ff + 1'b1;
            held_ff <= new_res;
         end
      end
      out_ff <= out_in;
   end

   always_comb begin
      status.no_pairs   = (pc_ff == '0) || (tc_ff == '0);
      status.scan_last  = (CWP'(si_ff) == pc_ff - 1'b1) && (CWT'(sj_ff) == tc_ff - 1'b1);
      status.pipe_empty = !(v1_ff || v2_ff || v3_ff || v4_ff);
      status.best_ok    = found_ff && (best_ff[KW-1 -: DW] <= max_ff);
      status.emit_done  = (ek_ff >= EW'(pc_ff) + EW'(tc_ff))
                          || (rcnt_ff == npms_pkg::ResCntW'(npms_pkg::MaxResults));
      status.survivor   = new_res.pt != '0;
      status.held_valid = held_v_ff;
      status.out_free   = !out_v_ff || rsp_tready;
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_result = out_ff;

endmodule

// ===== design/npms_ctrl.sv =====
// Controller: sequences loads, search rounds, pair updates and result emission.
module npms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_op,
   input  npms_pkg::status_type status,
   output npms_pkg::cmd_type    cmd
);

   localparam logic [3:0] StIdle    = 4'd0;
   localparam logic [3:0] StRound   = 4'd1;
   localparam logic [3:0] StScan    = 4'd2;
   localparam logic [3:0] StDrain   = 4'd3;
   localparam logic [3:0] StApplyRd = 4'd4;
   localparam logic [3:0] StApplyWr = 4'd5;
   localparam logic [3:0] StEmitRd  = 4'd6;
   localparam logic [3:0] StEmitChk = 4'd7;
   localparam logic [3:0] StEmitFin = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign req_tready = (state_ff == StIdle);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.addr_sel = npms_pkg::SelEmit;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               cmd.load_p    = req_op == npms_pkg::OpLoadParticle;
               cmd.load_t    = req_op == npms_pkg::OpLoadThermal;
               cmd.run_start = req_op == npms_pkg::OpRun;
               if (req_op == npms_pkg::OpRun) begin
                  state_in = StRound;
               end
            end
         end
         StRound: begin
            cmd.round_start = 1'b1;
            if (status.no_pairs) begin
               cmd.emit_start = 1'b1;
               state_in       = StEmitRd;
            end else begin
               state_in = StScan;
            end
         end
         StScan: begin
            cmd.addr_sel   = npms_pkg::SelScan;
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = StDrain;
            end
         end
         StDrain: begin
            cmd.addr_sel = npms_pkg::SelBest;
            if (status.pipe_empty) begin
               if (status.best_ok) begin
                  state_in = StApplyRd;
               end else begin
                  cmd.emit_start = 1'b1;
                  state_in       = StEmitRd;
               end
            end
         end
         StApplyRd: begin
            cmd.addr_sel = npms_pkg::SelBest;
            state_in     = StApplyWr;
         end
         StApplyWr: begin
            cmd.addr_sel = npms_pkg::SelBest;
            cmd.apply_wr = 1'b1;
            state_in     = StRound;
         end
         StEmitRd: begin
            state_in = status.emit_done ? StEmitFin : StEmitChk;
         end
         StEmitChk: begin
            // hold while a survivor needs the busy result register
            if (!(status.survivor && status.held_valid) || status.out_free) begin
               cmd.emit_take = 1'b1;
               state_in      = StEmitRd;
            end
         end
         StEmitFin: begin
            if (status.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/nearest_pair_momentum_subtraction_core.sv =====
// Top level of the nearest-pair momentum subtraction core.
//
// Input beats on req_*: op in req_tuser selects load particle, load thermal or run.
// A load into a full store is dropped and raises the
// overflow flag reported with the next run's results.
// A run visits pairs in ascending (distance, particle, thermal) order. Each visited
// pair costs one search round: a full sweep of P*T pairs through the pipelined
// distance calculation (one store read port each), so a run with R matched pairs
// takes R+1 search rounds before emission.
// Emission reads the stores one entry at a time, survivors in load order,
// particles first; rsp_tlast marks the final beat, and a run with no survivor
// yields a single beat of kind "nothing survived".
// req_tready is low throughout a run. A stalled receiver holds the result register
// and the emission walk. The matching limit is written through csr_we/csr_wdata
// while idle. Reset clears counts, flag and all control state and loads the limit with 2^20.
module nearest_pair_momentum_subtraction_core #(
   parameter int MAX_PARTICLES = npms_pkg::DefMaxParticles,
   parameter int MAX_THERMALS  = npms_pkg::DefMaxThermals
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pt[31:0], mass_excess[63:32], azimuth[78:64], rapidity[94:79],
   // species_id[126:95], zero pad[127]
   input  logic [127:0] req_tdata,
   // op[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_species[31:0], out_pt[63:32], out_mass_excess[95:64],
   // out_azimuth[110:96], out_rapidity[126:111], overflow[127]
   output logic [127:0] rsp_tdata,
   // kind[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [32:0]  csr_wdata
);

   npms_pkg::cmd_type    cmd;
   npms_pkg::status_type status;
   npms_pkg::item_type   req_item;
   npms_pkg::result_type res;

   assign req_item.pt      = req_tdata[31:0];
   assign req_item.mx      = req_tdata[63:32];
   assign req_item.az      = req_tdata[78:64];
   assign req_item.rap     = req_tdata[94:79];
   assign req_item.species = req_tdata[126:95];

   npms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   npms_datapath #(
      .MAX_PARTICLES (MAX_PARTICLES),
      .MAX_THERMALS  (MAX_THERMALS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_item   (req_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (res)
   );

   assign rsp_tdata = {res.overflow, res.rap, res.az, res.mx, res.pt, res.species};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last;

endmodule

// ===== design/npms_checker.sv =====
// Port-level checker for the nearest-pair momentum subtraction core, with its bind.
`include "nearest_pair_momentum_subtraction_core_macros.svh"

module npms_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast
);

   `NPMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `NPMS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `NPMS_ASSERT_NOW(a_busy_mid_run, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)
   `NPMS_ASSERT_NOW(a_none_last, clock, reset, rsp_tvalid && rsp_tuser == npms_pkg::KindNone, rsp_tlast)
   `NPMS_ASSERT_NOW(a_none_empty, clock, reset, rsp_tvalid && rsp_tuser == npms_pkg::KindNone, rsp_tdata[126:0] == '0)

endmodule

bind nearest_pair_momentum_subtraction_core npms_checker u_npms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the nearest-pair momentum subtraction core.
`timescale 1ns / 1ps

class subtraction_scoreboard;
   npms_pkg::item_type   particles[$];
   npms_pkg::item_type   thermals[$];
   npms_pkg::result_type pending_results[$];
   bit                   dropped;
   logic [32:0]          match_limit;
   int                   fails;

   function new();
      match_limit = npms_pkg::MaxDistReset;
      dropped     = 1'b0;
      fails       = 0;
   endfunction

   function void add_result(logic [1:0] kind, npms_pkg::item_type it);
      npms_pkg::result_type r;
      r.kind     = kind;
      r.species  = it.species;
      r.pt       = it.pt;
      r.mx       = it.mx;
      r.az       = it.az;
      r.rap      = it.rap;
      r.overflow = dropped;
      r.last     = 1'b0;
      pending_results = {pending_results, r};
   endfunction

   function void subtract_and_emit();
      bit [63:0]          pair_keys[$];
      longint             dphi, dy;
      bit [63:0]          d;
      int                 pi, tj, count;
      npms_pkg::item_type blank;
      foreach (particles[i]) foreach (thermals[j]) begin
         dphi = longint'(particles[i].az) - longint'(thermals[j].az);
         dy   = longint'(particles[i].rap) - longint'(thermals[j].rap);
         if (dphi < 0) dphi = -dphi;
         if (dphi > npms_pkg::PiQ) dphi = npms_pkg::TwoPiQ - dphi;
         d = dphi * dphi + dy * dy;
         pair_keys = {pair_keys, (d << 14) | (64'(i) << 7) | 64'(j)};
      end
      pair_keys.sort();
      foreach (pair_keys[k]) begin
         if ((pair_keys[k] >> 14) > match_limit) break;
         pi = pair_keys[k][13:7];
         tj = pair_keys[k][6:0];
         if (particles[pi].pt > thermals[tj].pt) begin
            particles[pi].pt -= thermals[tj].pt;
            thermals[tj].pt = 0;
         end else begin
            thermals[tj].pt -= particles[pi].pt;
            particles[pi].pt = 0;
         end
         if (particles[pi].mx > thermals[tj].mx) begin
            particles[pi].mx -= thermals[tj].mx;
            thermals[tj].mx = 0;
         end else begin
            thermals[tj].mx -= particles[pi].mx;
            particles[pi].mx = 0;
         end
      end
      count = 0;
      foreach (particles[i]) if (particles[i].pt != 0) begin
         add_result(npms_pkg::KindParticle, particles[i]);
         count++;
      end
      foreach (thermals[i]) if (thermals[i].pt != 0) begin
         add_result(npms_pkg::KindThermal, thermals[i]);
         count++;
      end
      if (count == 0) begin
         blank = '0;
         add_result(npms_pkg::KindNone, blank);
      end
      pending_results[$].last = 1'b1;
      particles.delete();
      thermals.delete();
      dropped = 1'b0;
   endfunction

   function void note_input(logic [1:0] op, npms_pkg::item_type it);
      case (op)
         npms_pkg::OpLoadParticle: begin
            if (particles.size() < npms_pkg::DefMaxParticles) particles = {particles, it};
            else dropped = 1'b1;
         end
         npms_pkg::OpLoadThermal: begin
            it.species = '0;
            if (thermals.size() < npms_pkg::DefMaxThermals) thermals = {thermals, it};
            else dropped = 1'b1;
         end
         npms_pkg::OpRun: subtract_and_emit();
         default: ;
      endcase
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         fails++;
      end
   endfunction

   function void check_result(npms_pkg::result_type got);
      npms_pkg::result_type want;
      if (pending_results.size() == 0) begin
         $error("unexpected result beat: kind %0d", got.kind);
         fails++;
         return;
      end
      want = pending_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("out_species", want.species, got.species);
      compare_field("out_pt", want.pt, got.pt);
      compare_field("out_mass_excess", want.mx, got.mx);
      compare_field("out_azimuth", 64'(want.az), 64'(got.az));
      compare_field("out_rapidity", 64'(want.rap), 64'(got.rap));
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("last", want.last, got.last);
   endfunction
endclass

module testbench;

   localparam int CycleLimit = 3000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0]   req_tuser = npms_pkg::OpLoadParticle;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [32:0]  csr_wdata = '0;

   subtraction_scoreboard sb = new();
   int    send_idle_pct;
   int    recv_stall_pct;
   int    items_sent;
   int    cycles;
   int    az_center;

   nearest_pair_momentum_subtraction_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("testbench failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      npms_pkg::result_type r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         r.kind     = rsp_tuser;
         r.species  = rsp_tdata[31:0];
         r.pt       = rsp_tdata[63:32];
         r.mx       = rsp_tdata[95:64];
         r.az       = rsp_tdata[110:96];
         r.rap      = rsp_tdata[126:111];
         r.overflow = rsp_tdata[127];
         r.last     = rsp_tlast;
         sb.check_result(r);
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_beat(logic [1:0] op, npms_pkg::item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, it.species, it.rap, it.az, it.mx, it.pt};
      do @(posedge clock); while (!req_tready);
      sb.note_input(op, it);
      if (op != npms_pkg::OpUnused) items_sent++;
   endtask

   task automatic write_limit(logic [32:0] value);
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.match_limit = value;
   endtask

   function automatic npms_pkg::item_type make_item(logic [31:0] pt, logic [31:0] mx,
                                                    int az, int rap, logic [31:0] species);
      npms_pkg::item_type it;
      it.pt      = pt;
      it.mx      = mx;
      it.az      = az[14:0];
      it.rap     = rap[15:0];
      it.species = species;
      return it;
   endfunction

   function automatic logic [31:0] rand_amount();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(1, 5000);
      endcase
   endfunction

   function automatic npms_pkg::item_type rand_item();
      int az, rap;
      az  = az_center + $urandom_range(0, 1600) - 800;
      if (az > npms_pkg::PiQ) az = npms_pkg::PiQ;
      if (az < -npms_pkg::PiQ) az = -npms_pkg::PiQ;
      rap = $urandom_range(0, 1600) - 800;
      if ($urandom_range(7) == 0) az = $urandom;
      if ($urandom_range(7) == 0) rap = $urandom;
      return make_item(rand_amount(), rand_amount(), az, rap, $urandom);
   endfunction

   task automatic random_event(int max_p, int max_t);
      int np, nt;
      np = $urandom_range(0, max_p);
      nt = $urandom_range(0, max_t);
      case ($urandom_range(3))
         0: az_center = 12500;
         1: az_center = -12500;
         2: az_center = 0;
         default: az_center = $urandom_range(0, 20000) - 10000;
      endcase
      while (np + nt > 0) begin
         if ($urandom_range(15) == 0) send_beat(npms_pkg::OpUnused, rand_item());
         if (nt == 0 || (np > 0 && $urandom_range(1))) begin
            send_beat(npms_pkg::OpLoadParticle, rand_item());
            np--;
         end else begin
            send_beat(npms_pkg::OpLoadThermal, rand_item());
            nt--;
         end
      end
      send_beat(npms_pkg::OpRun, rand_item());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_limit(npms_pkg::MaxDistReset);
      send_beat(npms_pkg::OpRun, make_item(0, 0, 0, 0, 0));
      send_beat(npms_pkg::OpLoadParticle,
                make_item(32'hFFFF_FFFF, 0, npms_pkg::PiQ, 32767, 32'h8000_0000));
      send_beat(npms_pkg::OpLoadThermal,
                make_item(1, 32'hFFFF_FFFF, -npms_pkg::PiQ, 32767, 32'h7FFF_FFFF));
      send_beat(npms_pkg::OpLoadParticle, make_item(5, 7, 0, -32768, 32'hFFFF_FFFF));
      send_beat(npms_pkg::OpLoadThermal, make_item(5, 7, 100, -32768, 1));
      send_beat(npms_pkg::OpUnused, make_item(9, 9, 0, 0, 9));
      send_beat(npms_pkg::OpLoadParticle, make_item(0, 3, -16384, 0, 2));
      send_beat(npms_pkg::OpLoadThermal, make_item(40, 3, 16383, 0, 3));
      send_beat(npms_pkg::OpRun, make_item(0, 0, 0, 0, 0));
      send_beat(npms_pkg::OpLoadThermal, make_item(8, 8, 200, 200, 4));
      send_beat(npms_pkg::OpLoadThermal, make_item(9, 9, 210, 210, 5));
      send_beat(npms_pkg::OpLoadParticle, make_item(12, 20, 205, 205, 6));
      send_beat(npms_pkg::OpRun, make_item(0, 0, 0, 0, 0));
      send_beat(npms_pkg::OpLoadParticle, make_item(1, 1, 0, 0, 7));
      send_beat(npms_pkg::OpRun, make_item(0, 0, 0, 0, 0));

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0; end
            1: begin send_idle_pct = 71; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         case (phase)
            0: write_limit(npms_pkg::MaxDistReset);
            1: write_limit(33'h1_FFFF_FFFF);
            2: write_limit(33'($urandom & 32'h003F_FFFF));
            default: write_limit('0);
         endcase
         if (phase == 3) begin
            for (int i = 0; i < 34; i++) send_beat(npms_pkg::OpLoadParticle, rand_item());
            for (int i = 0; i < 33; i++) send_beat(npms_pkg::OpLoadThermal, rand_item());
            send_beat(npms_pkg::OpRun, rand_item());
         end
         while (items_sent < 20 + 23 * (phase + 1) + (phase == 3 ? 68 : 0))
            random_event(phase == 1 ? 3 : 6, phase == 1 ? 3 : 6);
      end

      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.fails == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
